### hw/rtl/bfbp_pkg.sv
package bfbp_pkg;

  localparam int DEF_MAX_BINS   = 64;
  localparam int DEF_SIZE_WIDTH = 16;

  // fixed field widths of the ports
  localparam int ITEM_W    = 16;
  localparam int IDX_OUT_W = 6;
  localparam int CNT_OUT_W = 7;

  localparam logic [ITEM_W-1:0] CAP_RESET = 16'd100;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } bfbp_state_t;

endpackage

### hw/rtl/bfbp_load_ram.sv
module bfbp_load_ram #(
  parameter int DEPTH  = bfbp_pkg::DEF_MAX_BINS,
  parameter int DATA_W = bfbp_pkg::DEF_SIZE_WIDTH,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/best_fit_bin_packer.sv
// Online best-fit bin packer. Pulse start with in_item_size / in_start_new while busy is
// low; the block then scans the load of every open bin out of a single-port-read load
// memory, one bin per cycle, keeps the fullest bin that still fits, and writes back one
// load unless the item is dropped. The open bins scanned are counted after the
// in_start_new clear. The result appears for exactly one cycle on out_valid, in the
// cycle in which busy first reads low; there is no backpressure, so sample it then. A
// new item may be started in that same cycle. bin_capacity is written through
// cfg_valid/cfg_data (always ready); the user must write it only while the block is
// idle, the block itself does not enforce this; it resets to 100.
module best_fit_bin_packer #(
  parameter int MAX_BINS   = bfbp_pkg::DEF_MAX_BINS,
  parameter int SIZE_WIDTH = bfbp_pkg::DEF_SIZE_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [bfbp_pkg::ITEM_W-1:0]       in_item_size,
  input  logic                              in_start_new,
  output logic                              out_valid,
  output logic [bfbp_pkg::IDX_OUT_W-1:0]    out_bin_index,
  output logic                              out_opened_new,
  output logic                              out_oversize,
  output logic                              out_dropped,
  output logic [bfbp_pkg::CNT_OUT_W-1:0]    out_bins_used,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bfbp_pkg::ITEM_W-1:0]       cfg_data
);

  import bfbp_pkg::*;

  localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CNT_W = $clog2(MAX_BINS + 1);
  localparam int SZ_W  = (SIZE_WIDTH < ITEM_W) ? SIZE_WIDTH : ITEM_W;
  localparam int CMP_W = ((SIZE_WIDTH > ITEM_W) ? SIZE_WIDTH : ITEM_W) + 1;

  bfbp_state_t state_r, state_nxt;

  logic [ITEM_W-1:0]     cap_r;
  logic [SZ_W-1:0]       size_r, size_nxt;
  logic [CNT_W-1:0]      open_cnt_r, open_cnt_nxt;
  logic [CNT_W-1:0]      addr_r, addr_nxt;
  logic                  pend_r, pend_nxt;
  logic [IDX_W-1:0]      pend_idx_r, pend_idx_nxt;
  logic                  found_r, found_nxt;
  logic [IDX_W-1:0]      best_r, best_nxt;
  logic [SIZE_WIDTH-1:0] best_load_r, best_load_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]      out_idx_r, out_idx_nxt;
  logic                  out_opened_r, out_opened_nxt;
  logic                  out_over_r, out_over_nxt;
  logic                  out_drop_r, out_drop_nxt;

  logic                  accept;
  logic                  issue;
  logic                  fits;
  logic                  rd_en;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [SIZE_WIDTH-1:0] wr_data;
  logic [SIZE_WIDTH-1:0] rd_data;
  logic [31:0]           idx_ext;
  logic [31:0]           cnt_ext;

  bfbp_load_ram #(
    .DEPTH  (MAX_BINS),
    .DATA_W (SIZE_WIDTH),
    .ADDR_W (IDX_W)
  ) u_load_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (addr_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign issue     = (state_r == ST_SCAN) && (addr_r < open_cnt_r);
  assign rd_en     = issue;
  assign fits      = (CMP_W'(rd_data) + CMP_W'(size_r)) <= CMP_W'(cap_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      open_cnt_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      open_cnt_r  <= open_cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r       <= size_nxt;
    addr_r       <= addr_nxt;
    pend_idx_r   <= pend_idx_nxt;
    found_r      <= found_nxt;
    best_r       <= best_nxt;
    best_load_r  <= best_load_nxt;
    out_idx_r    <= out_idx_nxt;
    out_opened_r <= out_opened_nxt;
    out_over_r   <= out_over_nxt;
    out_drop_r   <= out_drop_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    size_nxt       = size_r;
    open_cnt_nxt   = open_cnt_r;
    addr_nxt       = addr_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = addr_r[IDX_W-1:0];
    found_nxt      = found_r;
    best_nxt       = best_r;
    best_load_nxt  = best_load_r;
    out_valid_nxt  = 1'b0;
    out_idx_nxt    = out_idx_r;
    out_opened_nxt = out_opened_r;
    out_over_nxt   = out_over_r;
    out_drop_nxt   = out_drop_r;
    wr_en          = 1'b0;
    wr_addr        = best_r;
    wr_data        = best_load_r + SIZE_WIDTH'(size_r);

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          size_nxt  = in_item_size[SZ_W-1:0];
          addr_nxt  = '0;
          found_nxt = 1'b0;
          if (in_start_new) begin
            open_cnt_nxt = '0;
          end
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // issue one read per cycle, compare the load returned from the previous one
        if (issue) begin
          addr_nxt = addr_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end
        if (pend_r && fits && (!found_r || rd_data > best_load_r)) begin
          found_nxt     = 1'b1;
          best_nxt      = pend_idx_r;
          best_load_nxt = rd_data;
        end
        // the last compare lands in the same edge that enters the decision
        if (!issue) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        out_valid_nxt  = 1'b1;
        out_over_nxt   = ITEM_W'(size_r) > cap_r;
        out_opened_nxt = 1'b0;
        out_drop_nxt   = 1'b0;
        if (found_r) begin
          wr_en       = 1'b1;
          out_idx_nxt = best_r;
        end else if (open_cnt_r < CNT_W'(MAX_BINS)) begin
          // open a new bin at the end, loaded with the item alone
          wr_en          = 1'b1;
          wr_addr        = open_cnt_r[IDX_W-1:0];
          wr_data        = SIZE_WIDTH'(size_r);
          out_idx_nxt    = open_cnt_r[IDX_W-1:0];
          out_opened_nxt = 1'b1;
          open_cnt_nxt   = open_cnt_r + CNT_W'(1);
        end else begin
          out_idx_nxt  = '0;
          out_drop_nxt = 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign idx_ext = 32'(out_idx_r);
  assign cnt_ext = 32'(open_cnt_r);

  assign out_valid      = out_valid_r;
  assign out_bin_index  = idx_ext[IDX_OUT_W-1:0];
  assign out_opened_new = out_opened_r;
  assign out_oversize   = out_over_r;
  assign out_dropped    = out_drop_r;
  assign out_bins_used  = cnt_ext[CNT_OUT_W-1:0];

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  a_idle_at_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("result shown while still busy");

  a_drop_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_drop_r && out_opened_r))
    else $error("item both dropped and placed in a new bin");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    open_cnt_r <= CNT_W'(MAX_BINS))
    else $error("open bin count beyond capacity of load store");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy && !out_valid_r)
    else $error("accepted transaction did not start a scan");

endmodule
